>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the block RMS and peak meter.
// Depends on nothing; each user provides clk and rst_n in its scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks a property at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

>>> rtl/rpm_pkg.sv
// Shared types and constants of the block RMS and peak meter.
// Depends on nothing.
package rpm_pkg;

  localparam int SAMPLE_W   = 16;  // audio sample width
  localparam int COUNT_W    = 13;  // reported sample count width
  localparam int SQ_W       = 31;  // a square is at most 2^30
  localparam int MEAN_W     = 31;  // a mean of squares is at most 2^30
  localparam int ROOT_W     = 16;  // root of at most 2^30 is at most 2^15
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SQRT_STEPS = ROOT_W;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } in_t;

  typedef struct packed {
    logic        [ROOT_W-1:0]   rms_level;
    logic signed [SAMPLE_W-1:0] peak_sample;
    logic        [COUNT_W-1:0]  sample_count;
  } out_t;

  // Status of a serial arithmetic engine.
  typedef struct packed {
    logic busy;
    logic done;
  } eng_stat_t;

endpackage

>>> rtl/rpm_accum.sv
// Per-sample accumulator: squares, running sum, peak and block length.
// Depends on rpm_pkg.
module rpm_accum #(
  parameter int MAX_BLOCK = 4096,
  parameter int SUM_W     = 43,
  parameter int LEN_W     = 13
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_fire,
  input  rpm_pkg::in_t                        in_data,
  output logic                                close_pending,
  output logic                                close_valid,
  output logic [SUM_W-1:0]                    close_sum,
  output logic [LEN_W-1:0]                    close_len,
  output logic signed [rpm_pkg::SAMPLE_W-1:0] close_peak
);

  localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_BLOCK);

  function automatic logic [rpm_pkg::SAMPLE_W-1:0] mag16(
    input logic [rpm_pkg::SAMPLE_W-1:0] s
  );
    return s[rpm_pkg::SAMPLE_W-1] ? (~s + 1'b1) : s;
  endfunction

  logic [rpm_pkg::SQ_W-1:0]            sq_r;
  logic                                sq_vld_r;
  logic                                close_r;
  logic [SUM_W-1:0]                    sum_r;
  logic [LEN_W-1:0]                    len_r;
  logic signed [rpm_pkg::SAMPLE_W-1:0] peak_r;
  logic [LEN_W-1:0]                    clen_r;
  logic signed [rpm_pkg::SAMPLE_W-1:0] cpeak_r;

  logic [rpm_pkg::SAMPLE_W-1:0]        mag;
  logic [2*rpm_pkg::SAMPLE_W-1:0]      prod;
  logic [LEN_W-1:0]                    len_inc;
  logic                                close_now;
  logic signed [rpm_pkg::SAMPLE_W-1:0] peak_sel;
  logic [SUM_W-1:0]                    sum_inc;

  assign mag       = mag16(in_data.sample);
  assign prod      = mag * mag;
  assign len_inc   = len_r + 1'b1;
  assign close_now = in_data.last || (len_inc == MaxLen);
  // The first sample of a block always takes the peak; ties keep the older one.
  assign peak_sel  = ((len_r == '0) || (mag > mag16(peak_r))) ? in_data.sample : peak_r;
  assign sum_inc   = sum_r + SUM_W'(sq_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      close_r  <= 1'b0;
      sum_r    <= '0;
      len_r    <= '0;
      peak_r   <= '0;
    end else begin
      sq_vld_r <= in_fire;
      close_r  <= in_fire && close_now;
      if (in_fire) begin
        if (close_now) begin
          len_r  <= '0;
          peak_r <= '0;
        end else begin
          len_r  <= len_inc;
          peak_r <= peak_sel;
        end
      end
      // The square of the closing sample is folded in on its way out.
      if (sq_vld_r) begin
        if (close_r) begin
          sum_r <= '0;
        end else begin
          sum_r <= sum_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      sq_r <= rpm_pkg::SQ_W'(prod);
      if (close_now) begin
        clen_r  <= len_inc;
        cpeak_r <= peak_sel;
      end
    end
  end

  assign close_pending = close_r;
  assign close_valid   = close_r;
  assign close_sum     = sum_inc;
  assign close_len     = clen_r;
  assign close_peak    = cpeak_r;

endmodule

>>> rtl/rpm_div.sv
// Restoring divider that retires one quotient bit per cycle.
// Depends on rpm_pkg.
module rpm_div #(
  parameter int SUM_W = 43,
  parameter int LEN_W = 13
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [SUM_W-1:0]               dividend,
  input  logic [LEN_W-1:0]               divisor,
  output logic [rpm_pkg::MEAN_W-1:0]     quotient,
  output rpm_pkg::eng_stat_t             stat
);

  localparam int              CNT_W = $clog2(SUM_W + 1);
  localparam logic [CNT_W-1:0] Steps = CNT_W'(SUM_W);

  logic [SUM_W-1:0]           dvd_r;
  logic [LEN_W-1:0]           dvs_r;
  logic [LEN_W-1:0]           rem_r;
  logic [rpm_pkg::MEAN_W-1:0] quo_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [LEN_W:0]             trial;
  logic [LEN_W:0]             diff;
  logic                       ge;

  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= Steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // A mean of squares never exceeds 2^30, so the quotient's upper bits stay zero.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[SUM_W-2:0], 1'b0};
      rem_r <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      quo_r <= {quo_r[rpm_pkg::MEAN_W-2:0], ge};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/rpm_sqrt.sv
// Integer square root that retires one root bit per cycle.
// Depends on rpm_pkg.
module rpm_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rpm_pkg::MEAN_W-1:0] radicand,
  output logic [rpm_pkg::ROOT_W-1:0] root,
  output rpm_pkg::eng_stat_t         stat
);

  localparam int               CNT_W = $clog2(rpm_pkg::SQRT_STEPS + 1);
  localparam int               REM_W = rpm_pkg::ROOT_W + 2;
  localparam logic [CNT_W-1:0] Steps = CNT_W'(rpm_pkg::SQRT_STEPS);

  logic [rpm_pkg::RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]           rem_r;
  logic [rpm_pkg::ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [REM_W+1:0]           trial;
  logic [REM_W+1:0]           test;
  logic [REM_W+1:0]           diff;
  logic                       ge;

  // Bring down two radicand bits and try the next root bit.
  assign trial = {rem_r, rad_r[rpm_pkg::RAD_W-1 -: 2]};
  assign test  = (REM_W + 2)'({root_r, 2'b01});
  assign ge    = trial >= test;
  assign diff  = trial - test;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= Steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rpm_pkg::RAD_W'(radicand);
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[rpm_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      root_r <= {root_r[rpm_pkg::ROOT_W-2:0], ge};
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> rtl/block_rms_and_peak_meter.sv
// Block RMS and peak meter: accumulator, serial divider, serial root, output register.
// Depends on rpm_pkg, rpm_accum, rpm_div, rpm_sqrt and assert_macros.svh.
//
// Samples are taken one per cycle while a block is open. The sample that closes a
// block (marked last, or the MAX_BLOCK-th) starts the end-of-block work, and in_ready
// stays low until that block's result sits in the output register: the accumulator
// flags the close, the bit-serial divider works through its SUM_W dividend bits
// (SUM_W = 31 + clog2(MAX_BLOCK), 43 at the default) and raises its done flag, the
// bit-serial square root runs and raises its done flag, and the output register is
// loaded. in_ready rises in the same cycle as out_valid. The load waits while an
// earlier result is still held in the output register. The next block may stream in
// while that result waits to be taken.
`include "assert_macros.svh"

module block_rms_and_peak_meter #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rpm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rpm_pkg::out_t out_data
);

  localparam int SUM_W = 31 + $clog2(MAX_BLOCK);
  localparam int LEN_W = $clog2(MAX_BLOCK + 1);

  logic                                in_fire;
  logic                                close_pending;
  logic                                close_valid;
  logic [SUM_W-1:0]                    close_sum;
  logic [LEN_W-1:0]                    close_len;
  logic signed [rpm_pkg::SAMPLE_W-1:0] close_peak;
  logic [rpm_pkg::MEAN_W-1:0]          mean;
  logic [rpm_pkg::ROOT_W-1:0]          root;
  rpm_pkg::eng_stat_t                  div_stat;
  rpm_pkg::eng_stat_t                  sqrt_stat;

  logic                                busy_r;
  logic                                res_pend_r;
  logic                                out_valid_r;
  rpm_pkg::out_t                       out_data_r;
  logic                                load;

  assign in_ready = !busy_r && !close_pending;
  assign in_fire  = in_valid && in_ready;
  assign load     = res_pend_r && (!out_valid_r || out_ready);

  rpm_accum #(
    .MAX_BLOCK (MAX_BLOCK),
    .SUM_W     (SUM_W),
    .LEN_W     (LEN_W)
  ) u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .in_data       (in_data),
    .close_pending (close_pending),
    .close_valid   (close_valid),
    .close_sum     (close_sum),
    .close_len     (close_len),
    .close_peak    (close_peak)
  );

  rpm_div #(
    .SUM_W (SUM_W),
    .LEN_W (LEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (close_valid),
    .dividend (close_sum),
    .divisor  (close_len),
    .quotient (mean),
    .stat     (div_stat)
  );

  rpm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_stat.done),
    .radicand (mean),
    .root     (root),
    .stat     (sqrt_stat)
  );

  // The root and the captured peak and length hold until the next block closes,
  // which cannot happen before this transaction is loaded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (close_valid) begin
        busy_r <= 1'b1;
      end else if (load) begin
        busy_r <= 1'b0;
      end
      if (sqrt_stat.done) begin
        res_pend_r <= 1'b1;
      end else if (load) begin
        res_pend_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.rms_level    <= root;
      out_data_r.peak_sample  <= close_peak;
      out_data_r.sample_count <= rpm_pkg::COUNT_W'(close_len);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_NEVER(a_close_while_busy, close_valid && busy_r, "block closed while engines busy")
  `ASSERT_CLK(a_div_feeds_sqrt, div_stat.done |=> sqrt_stat.busy, "root did not start after divide")
  `ASSERT_CLK(a_sqrt_done_busy, sqrt_stat.done |-> busy_r && !res_pend_r, "stray root result")
  `ASSERT_NEVER(a_engines_overlap, div_stat.busy && sqrt_stat.busy, "divider and root overlap")

endmodule

>>> tb/sv/rpm_level_checker.sv
// Scoreboard for the block RMS and peak meter. It watches the sample and result
// channels, predicts each block's level, peak and count, and checks every result.
// Depends on rpm_pkg.
`timescale 1ns / 1ps

module rpm_level_checker #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  rpm_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  rpm_pkg::out_t out_data,
  output int            fail_count,
  output int            outstanding,
  output int            samples_seen,
  output int            levels_checked
);

  logic [63:0]                  energy = '0;
  logic [rpm_pkg::SAMPLE_W-1:0] peak = '0;
  int unsigned                  span = 0;
  rpm_pkg::out_t                level_q[$];
  int                           errs = 0;
  int                           n_samples = 0;
  int                           n_levels = 0;

  function automatic int magnitude(input logic [rpm_pkg::SAMPLE_W-1:0] s);
    int v;
    v = int'($signed(s));
    return (v < 0) ? -v : v;
  endfunction

  // Truncated square root, settled one result bit at a time from the top.
  function automatic logic [rpm_pkg::ROOT_W-1:0] floor_root(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root[rpm_pkg::ROOT_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errs++;
  endtask

  always @(posedge clk) begin : watch
    rpm_pkg::out_t lvl;
    rpm_pkg::out_t got;
    int            mag;
    if (!rst_n) begin
      energy = '0;
      peak   = '0;
      span   = 0;
      level_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        mag = magnitude(in_data.sample);
        energy += 64'(mag) * 64'(mag);
        // The first sample always takes the peak; ties keep the earlier one.
        if (span == 0 || mag > magnitude(peak)) peak = in_data.sample;
        span++;
        n_samples++;
        if (in_data.last || span >= MAX_BLOCK) begin
          lvl.rms_level    = floor_root(energy / 64'(span));
          lvl.peak_sample  = peak;
          lvl.sample_count = rpm_pkg::COUNT_W'(span);
          level_q.insert(level_q.size(), lvl);
          energy = '0;
          peak   = '0;
          span   = 0;
        end
      end
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          report_mismatch("result transaction while no block had closed");
        end else begin
          lvl = level_q.pop_front();
          got = out_data;
          n_levels++;
          if (got.rms_level !== lvl.rms_level)
            report_mismatch($sformatf("block %0d: rms_level %0d, expected %0d",
                                      n_levels, got.rms_level, lvl.rms_level));
          if (got.peak_sample !== lvl.peak_sample)
            report_mismatch($sformatf("block %0d: peak_sample %0d, expected %0d",
                                      n_levels, $signed(got.peak_sample),
                                      $signed(lvl.peak_sample)));
          if (got.sample_count !== lvl.sample_count)
            report_mismatch($sformatf("block %0d: sample_count %0d, expected %0d",
                                      n_levels, got.sample_count, lvl.sample_count));
        end
      end
    end
    fail_count     <= errs;
    outstanding    <= level_q.size();
    samples_seen   <= n_samples;
    levels_checked <= n_levels;
  end

endmodule

>>> tb/sv/tb_block_rms_and_peak_meter.sv
// Top of the block RMS and peak meter testbench: clock, reset, sample stimulus and
// a stalling result sink around the block, with rpm_level_checker doing the checks.
// Depends on rpm_pkg, rpm_level_checker and the block_rms_and_peak_meter RTL.
`timescale 1ns / 1ps

module tb_block_rms_and_peak_meter;

  localparam int MAX_BLOCK = 4096;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  rpm_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  rpm_pkg::out_t out_data;
  int            fail_count;
  int            outstanding;
  int            samples_seen;
  int            levels_checked;
  int            burst_left = 0;
  rx_mode_t      rx_mode = RX_OPEN;
  int            rx_left = 0;

  always #4 clk = ~clk;

  block_rms_and_peak_meter #(
    .MAX_BLOCK(MAX_BLOCK)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  rpm_level_checker #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .samples_seen  (samples_seen),
    .levels_checked(levels_checked)
  );

  // The sink changes its stall pattern every so often, from always ready to sparse.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_left   <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(16, 160);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        default:   out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_sample(input logic [rpm_pkg::SAMPLE_W-1:0] s, input bit l);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample: s, last: l};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic [rpm_pkg::SAMPLE_W-1:0] pick_sample(
    input logic [rpm_pkg::SAMPLE_W-1:0] prev
  );
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return rpm_pkg::SAMPLE_W'($urandom);
    if (sel < 62) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h8001;
        default: return 16'h0000;
      endcase
    end
    if (sel < 82) return rpm_pkg::SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
    // Repeats and negations give equal magnitudes within a block.
    if (sel < 91) return prev;
    return -prev;
  endfunction

  function automatic int pick_length();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 12);
    if (sel < 95) return $urandom_range(13, 60);
    return $urandom_range(61, 160);
  endfunction

  initial begin : stimulus
    logic [rpm_pkg::SAMPLE_W-1:0] s;
    int                           len;
    int                           sent;
    bit                           closing;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-sample blocks at the extremes.
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0001, 1'b1);
    // A mean that floors to zero.
    send_sample(-16'sd1, 1'b0);
    send_sample(16'h0000, 1'b1);
    // Equal magnitudes keep the earlier sample.
    send_sample(16'sd5, 1'b0);
    send_sample(-16'sd5, 1'b0);
    send_sample(16'sd3, 1'b1);
    send_sample(-16'sd7, 1'b0);
    send_sample(16'sd7, 1'b1);
    // The most negative sample outranks the most positive one.
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    // A leading zero still becomes the peak of an all-zero block.
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h5555, 1'b0);
    send_sample(16'hAAAA, 1'b1);

    sent = 0;
    s    = '0;
    while (sent < 650) begin
      len     = pick_length();
      // Now and then a block loses its mark and runs into the next one; the final
      // block is always closed so that its result is checked.
      closing = (sent + len >= 650) || ($urandom_range(0, 9) != 0);
      for (int k = 0; k < len; k++) begin
        s = pick_sample(s);
        send_sample(s, (k == len - 1) && closing);
      end
      sent += len;
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Streamed %0d samples and checked %0d block results, with extreme, tied",
             samples_seen, levels_checked);
    $display("and run-on blocks under bursty input and a stalling result sink.");
    if (fail_count == 0) begin
      $display("block_rms_and_peak_meter test passed");
    end else begin
      $display("block_rms_and_peak_meter test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timed out with %0d block results still outstanding.", outstanding);
    $display("block_rms_and_peak_meter test failed");
    $finish;
  end

endmodule
